// ===== hw/rtl/pdr_pkg.sv =====
// Package for the pin drive resolver: drive codes, result codes, resolution functions.
`timescale 1ns / 1ps
package pdr_pkg;

  localparam int LVL_W   = 17;
  localparam int QDEPTH  = 2;
  localparam int PTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(65536);
  localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(32768);
  localparam logic [LVL_W-1:0] LVL_ZERO = '0;

  localparam logic [1:0] MODE_EXT    = 2'd0;
  localparam logic [1:0] MODE_INT    = 2'd1;
  localparam logic [1:0] MODE_ANALOG = 2'd2;

  localparam logic KIND_DIGITAL = 1'b0;
  localparam logic KIND_ANALOG  = 1'b1;

  typedef enum logic [2:0] {
    DRV_FLOAT = 3'd0,
    DRV_PUP   = 3'd1,
    DRV_PDN   = 3'd2,
    DRV_ANA   = 3'd3,
    DRV_HIGH  = 3'd4,
    DRV_LOW   = 3'd5,
    DRV_SHORT = 3'd6
  } drive_e;

  typedef enum logic [1:0] {
    DIG_HIGH  = 2'd0,
    DIG_LOW   = 2'd1,
    DIG_SHORT = 2'd2
  } dig_e;

  // One queue entry: result snapshot of one item plus whether it makes two results.
  typedef struct packed {
    logic             two;
    dig_e             dig;
    logic [LVL_W-1:0] lvl;
  } pdr_entry_t;

  function automatic drive_e pdr_norm(input logic [2:0] c);
    drive_e r;
    r = (c == 3'd7) ? DRV_SHORT : drive_e'(c);
    return r;
  endfunction

  function automatic drive_e pdr_combine(input drive_e in_st, input drive_e ex_st);
    drive_e r;
    case (in_st)
      DRV_FLOAT: r = ex_st;
      DRV_PUP: begin
        if (ex_st == DRV_FLOAT)    r = DRV_PUP;
        else if (ex_st == DRV_PDN) r = DRV_FLOAT;
        else                       r = ex_st;
      end
      DRV_PDN: begin
        if (ex_st == DRV_FLOAT)    r = DRV_PDN;
        else if (ex_st == DRV_PUP) r = DRV_FLOAT;
        else                       r = ex_st;
      end
      DRV_ANA:  r = (ex_st inside {[DRV_ANA:DRV_SHORT]}) ? DRV_SHORT : DRV_ANA;
      DRV_HIGH: r = (ex_st inside {DRV_ANA, DRV_LOW, DRV_SHORT}) ? DRV_SHORT : DRV_HIGH;
      DRV_LOW:  r = (ex_st inside {DRV_ANA, DRV_HIGH, DRV_SHORT}) ? DRV_SHORT : DRV_LOW;
      default:  r = DRV_SHORT;
    endcase
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] pdr_level(input drive_e st,
                                                 input logic [LVL_W-1:0] stored);
    logic [LVL_W-1:0] r;
    case (st)
      DRV_PUP, DRV_HIGH: r = LVL_ONE;
      DRV_PDN, DRV_LOW:  r = LVL_ZERO;
      DRV_SHORT:         r = LVL_HALF;
      default:           r = stored;
    endcase
    return r;
  endfunction

  function automatic dig_e pdr_reading(input drive_e st, input logic [LVL_W-1:0] stored);
    dig_e r;
    case (st)
      DRV_PUP, DRV_HIGH: r = DIG_HIGH;
      DRV_PDN, DRV_LOW:  r = DIG_LOW;
      DRV_SHORT:         r = DIG_SHORT;
      default:           r = (stored > LVL_HALF) ? DIG_HIGH : DIG_LOW;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pdr_front.sv =====
// Front end: accepts items, updates pin state, classifies the results to emit.
`timescale 1ns / 1ps
module pdr_front
  import pdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          mode_i,
  input  logic [2:0]          state_code_i,
  input  logic signed [17:0]  analog_in_i,
  output logic                push_o,
  output pdr_entry_t          entry_o
);

  drive_e           ext_q, ext_d;
  drive_e           int_q, int_d;
  drive_e           res_q, res_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;

  drive_e           code;
  dig_e             prev_rd, after;
  logic [LVL_W-1:0] clamped;
  logic [1:0]       n_res;

  always_comb begin
    code    = pdr_norm(state_code_i);
    prev_rd = pdr_reading(res_q, lvl_q);
    ext_d   = ext_q;
    int_d   = int_q;
    lvl_d   = lvl_q;
    n_res   = 2'd0;

    if (analog_in_i[17])                   clamped = LVL_ZERO;
    else if (analog_in_i[LVL_W-1:0] > LVL_ONE) clamped = LVL_ONE;
    else                                   clamped = analog_in_i[LVL_W-1:0];

    case (mode_i)
      MODE_EXT:    ext_d = code;
      MODE_INT:    int_d = code;
      MODE_ANALOG: if (ext_q == DRV_ANA) lvl_d = clamped;
      default: ;
    endcase

    res_d = (mode_i == MODE_EXT || mode_i == MODE_INT) ? pdr_combine(int_d, ext_d) : res_q;
    after = pdr_reading(res_d, lvl_d);

    if (mode_i == MODE_EXT || mode_i == MODE_INT) begin
      n_res = (after != prev_rd) ? 2'd2 : 2'd0;
    end else if (mode_i == MODE_ANALOG && ext_q == DRV_ANA) begin
      n_res = (after != prev_rd) ? 2'd2 : 2'd1;
    end

    entry_o.two = (n_res == 2'd2);
    entry_o.dig = after;
    entry_o.lvl = pdr_level(res_d, lvl_d);
    push_o      = accept_i && (n_res != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= DRV_FLOAT;
      int_q <= DRV_FLOAT;
      res_q <= DRV_FLOAT;
      lvl_q <= LVL_ZERO;
    end else if (accept_i) begin
      ext_q <= ext_d;
      int_q <= int_d;
      res_q <= res_d;
      lvl_q <= lvl_d;
    end
  end

endmodule

// ===== hw/rtl/pdr_queue.sv =====
// Short FIFO of result snapshots between front and back.
`timescale 1ns / 1ps
module pdr_queue
  import pdr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pdr_entry_t wdata_i,
  input  logic       pop_i,
  output pdr_entry_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  pdr_entry_t        mem_q [QDEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i)  rd_q <= inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/pdr_back.sv =====
// Back end: expands queue entries into one or two result items on the output register.
`timescale 1ns / 1ps
module pdr_back
  import pdr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  pdr_entry_t       entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [1:0]       dig_o,
  output logic [LVL_W-1:0] lvl_o,
  output logic             last_o
);

  logic             vld_q, vld_d;
  logic             pend_q, pend_d;
  logic             kind_q, kind_d;
  logic             last_q, last_d;
  logic [1:0]       dig_q, dig_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic             load;

  always_comb begin
    load   = !vld_q || out_ready_i;
    vld_d  = vld_q;
    pend_d = pend_q;
    kind_d = kind_q;
    last_d = last_q;
    dig_d  = dig_q;
    lvl_d  = lvl_q;
    pop_o  = 1'b0;
    if (load) begin
      if (pend_q) begin
        // second item of a pair: same snapshot, analog kind
        vld_d  = 1'b1;
        kind_d = KIND_ANALOG;
        last_d = 1'b1;
        pend_d = 1'b0;
      end else if (!empty_i) begin
        pop_o  = 1'b1;
        vld_d  = 1'b1;
        kind_d = entry_i.two ? KIND_DIGITAL : KIND_ANALOG;
        last_d = !entry_i.two;
        pend_d = entry_i.two;
        dig_d  = entry_i.dig;
        lvl_d  = entry_i.lvl;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    last_q <= last_d;
    dig_q  <= dig_d;
    lvl_q  <= lvl_d;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;
  assign dig_o       = dig_q;
  assign lvl_o       = lvl_q;

endmodule

// ===== hw/rtl/pin_drive_resolver.sv =====
// Top level of the pin drive resolver: front end, result queue, back end.
// Results pass from the front through the result queue into the output register.
// Throughput: one input item per cycle while the two-entry result queue has room;
//   results leave at one per cycle from the output register while out_ready_i is
//   high, and an item making two results uses it twice; items making none skip it.
// Reset: both drive states and the resolved state are floating, level is zero,
//   queue and output register are empty.
`timescale 1ns / 1ps
module pin_drive_resolver
  import pdr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         state_code_i,
  input  logic signed [17:0] analog_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               signal_kind_o,
  output logic [1:0]         digital_level_o,
  output logic [16:0]        analog_out_o,
  output logic               last_o
);

  // Front accepts whenever the queue can take a snapshot; items that make no
  // result never touch the queue, but we keep the rule simple and uniform.
  logic       accept;
  logic       push, pop, full, empty;
  pdr_entry_t wr_entry, rd_entry;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  pdr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .state_code_i (state_code_i),
    .analog_in_i  (analog_in_i),
    .push_o       (push),
    .entry_o      (wr_entry)
  );

  // Each entry is the post-update snapshot; both results of a pair share it.
  pdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  pdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (rd_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (signal_kind_o),
    .dig_o       (digital_level_o),
    .lvl_o       (analog_out_o),
    .last_o      (last_o)
  );

endmodule
